// File: sv/chm_pkg.sv
package chm_pkg;

	localparam int MAX_BUCKETS  = 256;
	localparam int POOL_ENTRIES = 1024;

	localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
	localparam int IDX_W  = $clog2(POOL_ENTRIES);
	localparam int BKT_W  = $clog2(MAX_BUCKETS);
	localparam int NB_W   = $clog2(MAX_BUCKETS + 1);
	localparam int CNT_W  = 11;
	localparam int BCFG_W = 9;
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;

	localparam int MOD_DIGITS = 4;
	localparam int MOD_CYCLES = KEY_W / MOD_DIGITS;
	localparam int MODC_W     = $clog2(MOD_CYCLES);

	localparam logic [LINK_W-1:0] NIL_LINK   = LINK_W'(POOL_ENTRIES);
	localparam logic [BCFG_W-1:0] BCNT_RESET = BCFG_W'(16);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_MISS   = 2'd1,
		ST_FULL   = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_HEAD,
		S_HEADW,
		S_NODE,
		S_RESOLVE,
		S_FREAD,
		S_REM2,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [LINK_W-1:0] link;
	} node_t;

endpackage

// File: sv/chm_ram.sv
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/chm_mod.sv
module chm_mod import chm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  key,
	input  logic [NB_W-1:0]   divisor,
	output logic              done,
	output logic [BKT_W-1:0]  bucket
);

	logic [KEY_W-1:0]  dvd_q;
	logic [NB_W-1:0]   rem_q;
	logic [MODC_W-1:0] cnt_q;
	logic              neg_q;
	logic              run_q;
	logic              done_q;
	logic [NB_W:0]     r;
	logic [NB_W-1:0]   fix;

	always_comb begin
		r = {1'b0, rem_q};
		for (int i = 0; i < MOD_DIGITS; i++) begin
			r = {r[NB_W-1:0], dvd_q[KEY_W-1-i]};
			if (r >= {1'b0, divisor}) begin
				r = r - {1'b0, divisor};
			end
		end
	end

	always_comb begin
		fix = rem_q;
		if (neg_q && (rem_q != '0)) begin
			fix = divisor - rem_q;
		end
	end

	assign bucket = fix[BKT_W-1:0];
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MODC_W'(MOD_CYCLES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= key[KEY_W-1];
			dvd_q <= key[KEY_W-1] ? (~key + 1'b1) : key;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= r[NB_W-1:0];
			dvd_q <= dvd_q << MOD_DIGITS;
		end
	end

endmodule

// File: sv/chained_hash_map.sv
// channel  | direction | handshake              | words
// in       | input     | in_valid / in_stall    | cmd, key, value_in
// out      | output    | out_valid / out_stall  | status, value_out, entry_total, over_load
// cfg      | input     | cfg_valid / cfg_ready  | bucket_count
//
// A request, once taken, first has its bucket remainder computed (4 bits per cycle,
// then done), then one node memory read per chain step; an insert or remove that changes
// the map passes through an extra write state (S_FREAD or S_REM2) before its result.
// The next request can be taken in the same cycle as the result is presented.
// Reset clears all bucket heads through valid flops; untouched pool nodes are
// tracked by a fill pointer, so no clearing pass is needed.
// A result waiting under out_stall holds; the next request may run meanwhile.
module chained_hash_map import chm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              cmd,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [VAL_W-1:0] value_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] value_out,
	output logic [CNT_W-1:0]        entry_total,
	output logic                    over_load,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [BCFG_W-1:0]       bucket_count
);

	state_t state_q, state_nx;

	logic [BCFG_W-1:0] bcnt_q;
	logic [NB_W-1:0]   nbk;
	logic [1:0]        cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [BKT_W-1:0]  bucket_q;
	logic [LINK_W-1:0] head_q, cur_q, prev_q, free_head_q, fresh_q;
	logic [CNT_W-1:0]  count_q;
	node_t             nword_q, pword_q;
	logic              found_q;
	logic [1:0]        stat_q;
	logic [VAL_W-1:0]  vout_q;
	logic [MAX_BUCKETS-1:0] hvalid_q;
	logic              out_valid_q;

	logic              accept, fin_go, match;
	logic              mod_done;
	logic [BKT_W-1:0]  mod_bucket;
	logic [LINK_W-1:0] hd, next_free;

	logic              bk_we;
	logic [LINK_W-1:0] bk_wdata, bk_rdata;
	logic              nd_we;
	logic [IDX_W-1:0]  nd_waddr, nd_raddr;
	node_t             nd_wdata, nd_rdata;

	always_comb begin
		nbk = bcnt_q;
		if (bcnt_q == '0) begin
			nbk = NB_W'(1);
		end else if (bcnt_q > BCFG_W'(MAX_BUCKETS)) begin
			nbk = NB_W'(MAX_BUCKETS);
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign fin_go    = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign hd        = hvalid_q[bucket_q] ? bk_rdata : NIL_LINK;
	assign match     = (nd_rdata.key == key_q);
	assign next_free = (free_head_q >= fresh_q) ? (free_head_q + 1'b1) : nd_rdata.link;

	chm_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.key     (key),
		.divisor (nbk),
		.done    (mod_done),
		.bucket  (mod_bucket)
	);

	chm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_heads (
		.clk   (clk),
		.we    (bk_we),
		.waddr (bucket_q),
		.wdata (bk_wdata),
		.raddr (bucket_q),
		.rdata (bk_rdata)
	);

	chm_ram #(.WIDTH($bits(node_t)), .DEPTH(POOL_ENTRIES)) u_nodes (
		.clk   (clk),
		.we    (nd_we),
		.waddr (nd_waddr),
		.wdata (nd_wdata),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:    if (accept) state_nx = S_DIV;
			S_DIV:     if (mod_done) state_nx = S_HEAD;
			S_HEAD:    state_nx = S_HEADW;
			S_HEADW:   state_nx = (hd == NIL_LINK) ? S_RESOLVE : S_NODE;
			S_NODE: begin
				if (match || nd_rdata.link == NIL_LINK) begin
					state_nx = S_RESOLVE;
				end
			end
			S_RESOLVE: begin
				state_nx = S_FIN;
				if (cmd_q == CMD_INSERT && !found_q && free_head_q != NIL_LINK) begin
					state_nx = S_FREAD;
				end else if (cmd_q == CMD_REMOVE && found_q) begin
					state_nx = S_REM2;
				end
			end
			S_FREAD:   state_nx = S_FIN;
			S_REM2:    state_nx = S_FIN;
			S_FIN:     if (fin_go) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		bk_we    = 1'b0;
		bk_wdata = nword_q.link;
		nd_we    = 1'b0;
		nd_waddr = free_head_q[IDX_W-1:0];
		nd_wdata = '{key: key_q, value: val_q, link: head_q};
		nd_raddr = cur_q[IDX_W-1:0];
		case (state_q)
			S_HEADW: nd_raddr = hd[IDX_W-1:0];
			S_NODE:  nd_raddr = nd_rdata.link[IDX_W-1:0];
			S_RESOLVE: begin
				nd_raddr = free_head_q[IDX_W-1:0];
				if (cmd_q == CMD_REMOVE && found_q) begin
					if (prev_q == NIL_LINK) begin
						bk_we = 1'b1;
					end else begin
						nd_we    = 1'b1;
						nd_waddr = prev_q[IDX_W-1:0];
						nd_wdata = '{key: pword_q.key, value: pword_q.value,
							link: nword_q.link};
					end
				end
			end
			S_FREAD: begin
				nd_we    = 1'b1;
				bk_we    = 1'b1;
				bk_wdata = free_head_q;
			end
			S_REM2: begin
				nd_we    = 1'b1;
				nd_waddr = cur_q[IDX_W-1:0];
				nd_wdata = '{key: nword_q.key, value: nword_q.value, link: free_head_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bcnt_q      <= BCNT_RESET;
			hvalid_q    <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) begin
				bcnt_q <= bucket_count;
			end
			if (bk_we) begin
				hvalid_q[bucket_q] <= 1'b1;
			end
			if (state_q == S_FREAD) begin
				free_head_q <= next_free;
				if (free_head_q == fresh_q) begin
					fresh_q <= fresh_q + 1'b1;
				end
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_REM2) begin
				free_head_q <= cur_q;
				if (count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q   <= cmd;
				key_q   <= key;
				val_q   <= value_in;
				found_q <= 1'b0;
				prev_q  <= NIL_LINK;
			end
			S_DIV:   bucket_q <= mod_bucket;
			S_HEADW: begin
				head_q <= hd;
				cur_q  <= hd;
			end
			S_NODE: begin
				if (match) begin
					found_q <= 1'b1;
					nword_q <= nd_rdata;
				end else begin
					prev_q  <= cur_q;
					pword_q <= nd_rdata;
					cur_q   <= nd_rdata.link;
				end
			end
			S_RESOLVE: begin
				stat_q <= ST_OK;
				vout_q <= '0;
				case (cmd_q)
					CMD_INSERT: begin
						if (found_q) begin
							stat_q <= ST_MISS;
						end else if (free_head_q == NIL_LINK) begin
							stat_q <= ST_FULL;
						end
					end
					CMD_REMOVE: if (!found_q) stat_q <= ST_MISS;
					CMD_LOOKUP: begin
						if (found_q) begin
							vout_q <= nword_q.value;
						end else begin
							stat_q <= ST_MISS;
						end
					end
					default: ;
				endcase
			end
			S_FIN: begin
				if (fin_go) begin
					status      <= stat_q;
					value_out   <= vout_q;
					entry_total <= count_q;
					over_load   <= ({count_q, 2'b00} >
						((CNT_W + 2)'(nbk) * (CNT_W + 2)'(3)));
				end
			end
			default: ;
		endcase
	end

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NIL_LINK)
		else $error("fill pointer beyond pool");

	a_empty_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == NIL_LINK) |-> (count_q == CNT_W'(POOL_ENTRIES)))
		else $error("free list empty with pool not full");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && fin_go) |=> (out_valid && state_q == S_IDLE))
		else $error("finished request did not present a result");

endmodule

// File: tb/sv/chained_hash_map_tb.sv
module chained_hash_map_tb;
	import chm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic signed [KEY_W-1:0] key = '0;
	logic signed [VAL_W-1:0] value_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [VAL_W-1:0] value_out;
	logic [CNT_W-1:0] entry_total;
	logic over_load;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [BCFG_W-1:0] bucket_count = BCNT_RESET;

	chained_hash_map u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .key(key), .value_in(value_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_out(value_out),
		.entry_total(entry_total), .over_load(over_load),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.bucket_count(bucket_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	typedef struct {
		logic [1:0] status;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] total;
		logic over;
	} map_reply_t;

	typedef struct {
		cmd_t op;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		bit known;
		map_reply_t rep;
	} map_row_t;

	// map model state
	int unsigned mdl_nb;
	int unsigned mdl_heads[MAX_BUCKETS];
	logic [KEY_W-1:0] mdl_keys[POOL_ENTRIES];
	logic [VAL_W-1:0] mdl_vals[POOL_ENTRIES];
	int unsigned mdl_links[POOL_ENTRIES];
	int unsigned mdl_free;
	int unsigned mdl_count;

	map_reply_t pending_replies[$];
	logic [KEY_W-1:0] held_keys[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;

	function automatic int unsigned eff_buckets(int unsigned n);
		if (n == 0) return 1;
		if (n > MAX_BUCKETS) return MAX_BUCKETS;
		return n;
	endfunction

	function automatic int unsigned bucket_index(logic [KEY_W-1:0] k);
		longint s;
		longint r;
		s = longint'($signed(k));
		r = s % longint'(eff_buckets(mdl_nb));
		if (r < 0) r += eff_buckets(mdl_nb);
		return int'(r);
	endfunction

	function automatic map_reply_t map_apply(cmd_t op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		map_reply_t r;
		int unsigned b;
		int unsigned cur;
		int unsigned prev;
		int unsigned hit;
		int unsigned steps;
		r.status = ST_OK;
		r.value = '0;
		b = bucket_index(k);
		prev = POOL_ENTRIES;
		hit = POOL_ENTRIES;
		cur = mdl_heads[b];
		steps = 0;
		while (cur < POOL_ENTRIES && steps <= POOL_ENTRIES) begin
			if (mdl_keys[cur] == k) begin
				hit = cur;
				break;
			end
			prev = cur;
			cur = mdl_links[cur];
			steps++;
		end
		case (op)
			CMD_INSERT: begin
				if (hit != POOL_ENTRIES) r.status = ST_MISS;
				else if (mdl_free >= POOL_ENTRIES) r.status = ST_FULL;
				else begin
					cur = mdl_free;
					mdl_free = mdl_links[cur];
					mdl_keys[cur] = k;
					mdl_vals[cur] = v;
					mdl_links[cur] = mdl_heads[b];
					mdl_heads[b] = cur;
					mdl_count++;
				end
			end
			CMD_REMOVE: begin
				if (hit == POOL_ENTRIES) r.status = ST_MISS;
				else begin
					if (prev == POOL_ENTRIES) mdl_heads[b] = mdl_links[hit];
					else mdl_links[prev] = mdl_links[hit];
					mdl_links[hit] = mdl_free;
					mdl_free = hit;
					if (mdl_count > 0) mdl_count--;
				end
			end
			CMD_LOOKUP: begin
				if (hit == POOL_ENTRIES) r.status = ST_MISS;
				else r.value = mdl_vals[hit];
			end
			default: ;
		endcase
		r.total = mdl_count[CNT_W-1:0];
		r.over = (mdl_count * 4 > eff_buckets(mdl_nb) * 3);
		return r;
	endfunction

	task automatic send_word(cmd_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= op;
		key <= k;
		value_in <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic issue(cmd_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			bit known, map_reply_t rep);
		map_reply_t p;
		int i;
		p = map_apply(op, k, v);
		if (known && (p.status !== rep.status || p.value !== rep.value ||
				p.total !== rep.total || p.over !== rep.over)) begin
			$display("%0t table row key %h exp st=%0d v=%h n=%0d o=%0d got st=%0d v=%h n=%0d o=%0d",
				$time, k, rep.status, rep.value, rep.total, rep.over,
				p.status, p.value, p.total, p.over);
			errors++;
		end
		pending_replies.push_back(p);
		if (op == CMD_INSERT && p.status == ST_OK) held_keys.push_back(k);
		if (op == CMD_REMOVE && p.status == ST_OK)
			for (i = 0; i < held_keys.size(); i++)
				if (held_keys[i] == k) begin
					held_keys.delete(i);
					break;
				end
		send_word(op, k, v);
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	task automatic set_buckets(logic [BCFG_W-1:0] n);
		drain_and_settle();
		bucket_count <= n;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mdl_nb = n;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_replies.size() == 0) begin
					$display("%0t unexpected word status=%0d value=%h total=%0d",
						$time, status, value_out, entry_total);
					errors++;
				end else begin
					map_reply_t e;
					e = pending_replies.pop_front();
					if (status !== e.status || value_out !== e.value ||
							entry_total !== e.total || over_load !== e.over) begin
						$display("%0t mismatch exp st=%0d v=%h n=%0d o=%0d got st=%0d v=%h n=%0d o=%0d",
							$time, e.status, e.value, e.total, e.over,
							status, value_out, entry_total, over_load);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	function automatic map_reply_t rep(logic [1:0] s, logic [VAL_W-1:0] v,
			int unsigned n, bit o);
		map_reply_t r;
		r.status = s;
		r.value = v;
		r.total = n[CNT_W-1:0];
		r.over = o;
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if (held_keys.size() != 0 && $urandom_range(99) < 55)
			return held_keys[$urandom_range(held_keys.size() - 1)];
		if ($urandom_range(3) == 0) return KEY_W'($urandom_range(40)) - 20;
		return $urandom;
	endfunction

	task automatic random_phase(int n, int unsigned idle, int unsigned stl);
		cmd_t op;
		int i;
		send_idle = idle;
		recv_stall = stl;
		for (i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: op = CMD_INSERT;
				4, 5: op = CMD_REMOVE;
				6, 7, 8: op = CMD_LOOKUP;
				default: op = CMD_NOP;
			endcase
			issue(op, pick_key(), $urandom, 1'b0, rep(0, 0, 0, 0));
		end
		send_idle = 0;
		recv_stall = 0;
	endtask

	map_row_t directed[$];

	initial begin
		int i;
		map_row_t row;
		mdl_nb = BCNT_RESET;
		for (i = 0; i < MAX_BUCKETS; i++) mdl_heads[i] = POOL_ENTRIES;
		for (i = 0; i < POOL_ENTRIES; i++) mdl_links[i] = i + 1;
		mdl_free = 0;
		mdl_count = 0;

		directed = '{
			'{CMD_LOOKUP, 32'h0, 32'h0, 1, rep(ST_MISS, 0, 0, 0)},
			'{CMD_REMOVE, 32'h8000_0000, 32'h0, 1, rep(ST_MISS, 0, 0, 0)},
			'{CMD_NOP, 32'h7fff_ffff, 32'hffff_ffff, 1, rep(ST_OK, 0, 0, 0)},
			'{CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1, rep(ST_OK, 0, 1, 0)},
			'{CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1, rep(ST_OK, 0, 2, 0)},
			'{CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff, 1, rep(ST_OK, 0, 3, 0)},
			'{CMD_INSERT, 32'h0, 32'h0, 1, rep(ST_OK, 0, 4, 0)},
			'{CMD_INSERT, 32'hffff_ffff, 32'h1234_5678, 1, rep(ST_MISS, 0, 4, 0)},
			'{CMD_INSERT, 32'hffff_fff0, 32'h5555_aaaa, 0, rep(0, 0, 0, 0)},
			'{CMD_INSERT, 32'h10, 32'haaaa_5555, 0, rep(0, 0, 0, 0)},
			'{CMD_LOOKUP, 32'h8000_0000, 32'h0, 1, rep(ST_OK, 32'h7fff_ffff, 6, 0)},
			'{CMD_LOOKUP, 32'h7fff_ffff, 32'h0, 1, rep(ST_OK, 32'h8000_0000, 6, 0)},
			'{CMD_LOOKUP, 32'hffff_fff0, 32'h0, 0, rep(0, 0, 0, 0)},
			'{CMD_REMOVE, 32'h0, 32'h0, 0, rep(0, 0, 0, 0)},
			'{CMD_REMOVE, 32'hffff_fff0, 32'h0, 0, rep(0, 0, 0, 0)},
			'{CMD_LOOKUP, 32'h10, 32'h0, 0, rep(0, 0, 0, 0)},
			'{CMD_NOP, 32'h0, 32'h0, 0, rep(0, 0, 0, 0)},
			'{CMD_INSERT, 32'h0, 32'hdead_beef, 0, rep(0, 0, 0, 0)}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[j]) begin
			row = directed[j];
			issue(row.op, row.k, row.v, row.known, row.rep);
		end

		// one bucket, then stale chains after a shrink
		set_buckets(9'd1);
		issue(CMD_LOOKUP, 32'h7fff_ffff, 0, 0, rep(0, 0, 0, 0));
		issue(CMD_INSERT, 32'h2, 32'h2, 0, rep(0, 0, 0, 0));
		set_buckets(9'd0);
		issue(CMD_LOOKUP, 32'h2, 0, 0, rep(0, 0, 0, 0));
		issue(CMD_INSERT, 32'h3, 32'h3, 0, rep(0, 0, 0, 0));
		set_buckets(9'd511);
		issue(CMD_LOOKUP, 32'hffff_ffff, 0, 0, rep(0, 0, 0, 0));
		issue(CMD_INSERT, 32'h1ff, 32'h1, 0, rep(0, 0, 0, 0));
		set_buckets(9'd256);
		random_phase(130, 0, 0);
		set_buckets(9'd7);
		random_phase(130, 63, 0);
		set_buckets(9'd1);
		random_phase(100, 0, 63);
		set_buckets(9'd37);
		random_phase(120, 22, 22);

		// fill the pool to exercise the full status, mostly with quiet handshakes
		set_buckets(9'd256);
		while (mdl_free < POOL_ENTRIES)
			issue(CMD_INSERT, $urandom, $urandom, 0, rep(0, 0, 0, 0));
		issue(CMD_INSERT, $urandom, 32'h1, 0, rep(0, 0, 0, 0));
		random_phase(130, 22, 22);
		set_buckets(9'd16);
		random_phase(130, 0, 0);

		drain_and_settle();
		if (errors == 0)
			$display("PASS chained_hash_map");
		else
			$display("FAIL chained_hash_map");
		$finish;
	end

	initial begin
		#100ms;
		$display("FAIL chained_hash_map");
		$finish;
	end
endmodule

// File: sim.f
sv/chm_pkg.sv
sv/chm_ram.sv
sv/chm_mod.sv
sv/chained_hash_map.sv
tb/sv/chained_hash_map_tb.sv
